/* hw/rtl/fmenc_pkg.sv */
// Shared types, constants and coding functions for the Manchester frame encoder.
`default_nettype none
package fmenc_pkg;

	localparam logic       OP_HEADER     = 1'b0;
	localparam logic       OP_DATA       = 1'b1;

	localparam logic [7:0] CRC_POLY      = 8'h07;
	localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
	localparam logic [7:0] SYNC_BYTE     = 8'hCB;
	localparam logic [7:0] MAX_DATA_LEN  = 8'd253;
	localparam logic [7:0] LEN_OVERHEAD  = 8'd2;
	localparam logic [15:0] POST_WORD    = 16'h6600;

	localparam logic [4:0] CNT_FULL      = 5'd16;
	localparam logic [4:0] CNT_POST      = 5'd8;

	typedef logic [2:0] slot_t;

	localparam slot_t SLOT_PRE   = 3'd0;
	localparam slot_t SLOT_SYNC  = 3'd1;
	localparam slot_t SLOT_BYTE0 = 3'd2;
	localparam slot_t SLOT_TYPE  = 3'd3;
	localparam slot_t SLOT_SEQ   = 3'd4;
	localparam slot_t SLOT_CRC   = 3'd5;
	localparam slot_t SLOT_POST  = 3'd6;

	typedef struct packed {
		logic       is_hdr;
		logic       trailer;
		logic [7:0] byte0;
		logic [7:0] frame_kind;
		logic [7:0] seq_number;
		logic [7:0] crc;
	} job_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] v;
		v = c ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

	function automatic logic [15:0] manch(input logic [7:0] b);
		logic [15:0] w;
		w = '0;
		for (int i = 0; i < 8; i++) begin
			w[2*i +: 2] = b[i] ? 2'b01 : 2'b10;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fmenc_front.sv */
// Front end: accept items, track frame state and CRC, and issue coding jobs.
`default_nettype none
module fmenc_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             accept,
	input  wire             operation,
	input  wire [7:0]       frame_kind,
	input  wire [7:0]       seq_number,
	input  wire [7:0]       payload_length,
	input  wire [7:0]       data_byte,
	output logic            job_valid,
	output fmenc_pkg::job_t job
);
	import fmenc_pkg::*;

	logic [7:0] crc_q;
	logic [7:0] left_q;
	logic       in_frame_q;

	logic [7:0] plen_sat;
	logic [7:0] len_byte;
	logic [7:0] hdr_crc;
	logic [7:0] dat_crc;
	logic [7:0] left_dec;
	logic [7:0] crc_d;
	logic [7:0] left_d;
	logic       in_frame_d;

	always_comb begin
		plen_sat = (payload_length > MAX_DATA_LEN) ? MAX_DATA_LEN : payload_length;
		len_byte = plen_sat + LEN_OVERHEAD;
		hdr_crc  = crc8_byte(crc8_byte(crc8_byte(8'h00, len_byte), frame_kind), seq_number);
		dat_crc  = crc8_byte(crc_q, data_byte);
		left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : left_q;

		job_valid      = 1'b0;
		job.is_hdr     = 1'b0;
		job.trailer    = 1'b0;
		job.byte0      = data_byte;
		job.frame_kind = frame_kind;
		job.seq_number = seq_number;
		job.crc        = dat_crc;
		crc_d          = crc_q;
		left_d         = left_q;
		in_frame_d     = in_frame_q;

		if (operation == OP_HEADER) begin
			job_valid   = 1'b1;
			job.is_hdr  = 1'b1;
			job.byte0   = len_byte;
			job.crc     = hdr_crc;
			job.trailer = (plen_sat == 8'd0);
			if (plen_sat == 8'd0) begin
				crc_d      = 8'h00;
				left_d     = 8'd0;
				in_frame_d = 1'b0;
			end else begin
				crc_d      = hdr_crc;
				left_d     = plen_sat;
				in_frame_d = 1'b1;
			end
		end else if (in_frame_q) begin
			job_valid   = 1'b1;
			job.trailer = (left_dec == 8'd0);
			if (left_dec == 8'd0) begin
				crc_d      = 8'h00;
				left_d     = 8'd0;
				in_frame_d = 1'b0;
			end else begin
				crc_d      = dat_crc;
				left_d     = left_dec;
			end
		end

		job_valid = job_valid & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 8'h00;
			left_q     <= 8'd0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			crc_q      <= crc_d;
			left_q     <= left_d;
			in_frame_q <= in_frame_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fmenc_queue.sv */
// Short job queue between the front end and the word sequencer.
`default_nettype none
module fmenc_queue #(
	parameter int DEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_en,
	input  fmenc_pkg::job_t wr_job,
	output logic            full,
	input  wire             rd_en,
	output logic            rd_valid,
	output fmenc_pkg::job_t rd_job
);
	import fmenc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	job_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full     = (count_q == DEPTH_C);
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fmenc_back.sv */
// Back end: step through each job's words and hold the result register.
`default_nettype none
module fmenc_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             job_valid,
	input  fmenc_pkg::job_t job,
	output logic            job_pop,
	output logic            empty,
	input  wire             pop,
	output logic [15:0]     symbol_word,
	output logic [4:0]      symbol_count,
	output logic            last_of_run,
	output logic            frame_end
);
	import fmenc_pkg::*;

	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic [4:0]  count_q;
	logic        last_q;
	logic        end_q;

	slot_t       slot;
	logic [7:0]  cur_byte;
	logic        is_last;
	logic        load;

	always_comb begin
		if (job.is_hdr) begin
			slot = step_q;
		end else begin
			unique case (step_q)
				3'd0:    slot = SLOT_BYTE0;
				3'd1:    slot = SLOT_CRC;
				default: slot = SLOT_POST;
			endcase
		end

		unique case (slot)
			SLOT_PRE:   cur_byte = PREAMBLE_BYTE;
			SLOT_SYNC:  cur_byte = SYNC_BYTE;
			SLOT_BYTE0: cur_byte = job.byte0;
			SLOT_TYPE:  cur_byte = job.frame_kind;
			SLOT_SEQ:   cur_byte = job.seq_number;
			SLOT_CRC:   cur_byte = job.crc;
			default:    cur_byte = 8'h00;
		endcase

		if (job.trailer) begin
			is_last = (slot == SLOT_POST);
		end else if (job.is_hdr) begin
			is_last = (slot == SLOT_SEQ);
		end else begin
			is_last = (slot == SLOT_BYTE0);
		end
	end

	assign load    = job_valid & (~out_valid_q | pop);
	assign job_pop = load & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= is_last ? 3'd0 : step_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q  <= (slot == SLOT_POST) ? POST_WORD : manch(cur_byte);
			count_q <= (slot == SLOT_POST) ? CNT_POST : CNT_FULL;
			last_q  <= is_last;
			end_q   <= (slot == SLOT_POST);
		end
	end

	assign empty        = ~out_valid_q;
	assign symbol_word  = word_q;
	assign symbol_count = count_q;
	assign last_of_run  = last_q;
	assign frame_end    = end_q;

endmodule
`default_nettype wire

/* hw/rtl/manchester_frame_encoder_core.sv */
// Top level of the Manchester frame encoder with CRC-8.
//
// Input side is a queue: an item is taken on a clock edge with push high and
// full low. A header item (operation 0) opens a frame and yields five words
// (preamble, sync, length, type, sequence), plus CRC and postamble words when
// the payload length is zero. A data item (operation 1) inside a frame yields
// one word, followed by CRC and postamble after the last byte; outside a frame
// it is dropped.
// Result side is a one-entry register: the word sits on the ports while empty is
// low and leaves on an edge with pop high.
// The first word of an item passes through the job queue and then the result
// register before it is shown. The word sequencer emits one word per cycle
// while pop is held high, so data bytes other than the closing one stream at
// one item per cycle. The job queue of QUEUE_DEPTH entries lets the
// front end keep taking items while the sequencer works through a burst.
// A stalled result simply holds; full rises once the queue fills behind it.
// Reset empties the queue and result register and closes any open frame.
`default_nettype none
module manchester_frame_encoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire         operation,
	input  wire  [7:0]  frame_kind,
	input  wire  [7:0]  seq_number,
	input  wire  [7:0]  payload_length,
	input  wire  [7:0]  data_byte,
	output logic        empty,
	input  wire         pop,
	output logic [15:0] symbol_word,
	output logic [4:0]  symbol_count,
	output logic        last_of_run,
	output logic        frame_end
);
	import fmenc_pkg::*;

	logic  accept;
	logic  fe_valid;
	job_t  fe_job;
	logic  q_valid;
	job_t  q_job;
	logic  q_pop;

	assign accept = push & ~full;

	fmenc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.operation      (operation),
		.frame_kind     (frame_kind),
		.seq_number     (seq_number),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.job_valid      (fe_valid),
		.job            (fe_job)
	);

	fmenc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fe_valid),
		.wr_job   (fe_job),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_job   (q_job)
	);

	fmenc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_valid),
		.job          (q_job),
		.job_pop      (q_pop),
		.empty        (empty),
		.pop          (pop),
		.symbol_word  (symbol_word),
		.symbol_count (symbol_count),
		.last_of_run  (last_of_run),
		.frame_end    (frame_end)
	);

endmodule
`default_nettype wire

/* hw/rtl/fmenc_checker.sv */
// Port checker for the Manchester frame encoder and its bind statement.
`default_nettype none
module fmenc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        empty,
	input wire        pop,
	input wire [15:0] symbol_word,
	input wire [4:0]  symbol_count,
	input wire        last_of_run,
	input wire        frame_end
);
	import fmenc_pkg::*;

	a_post_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (symbol_count == CNT_POST && symbol_word == POST_WORD
			&& last_of_run))
		else $error("postamble beat malformed");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !frame_end) |-> (symbol_count == CNT_FULL))
		else $error("data beat symbol count wrong");

	a_manch_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !frame_end) |-> (((symbol_word ^ (symbol_word >> 1)) & 16'h5555) == 16'h5555))
		else $error("symbol pair not a Manchester code");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(symbol_word) && $stable(frame_end)))
		else $error("stalled beat changed");

endmodule

bind manchester_frame_encoder_core fmenc_checker u_fmenc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.symbol_word  (symbol_word),
	.symbol_count (symbol_count),
	.last_of_run  (last_of_run),
	.frame_end    (frame_end)
);
`default_nettype wire
